// File: rtl/rpk_pkg.sv
`timescale 1ns / 1ps

package rpk_pkg;

  // Field and register widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned WidthW = 6;

  // Word width limits and reset value
  localparam logic [WidthW-1:0] WidthMin   = 6'd8;
  localparam logic [WidthW-1:0] WidthMax   = 6'd32;
  localparam logic [WidthW-1:0] WidthReset = 6'd10;

  // One registered input byte
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] in_byte;
    logic             last_of_buffer;
  } rpk_item_t;

  // Result of one step toward the output register
  typedef struct packed {
    logic             step;
    logic             emit;
    logic [WordW-1:0] out_word;
  } rpk_result_t;

  // Clamp a raw width into the legal range
  function automatic logic [WidthW-1:0] clamp_width(input logic [WidthW-1:0] raw);
    logic [WidthW-1:0] w;
    w = raw;
    if (raw < WidthMin) begin
      w = WidthMin;
    end else if (raw > WidthMax) begin
      w = WidthMax;
    end
    return w;
  endfunction

endpackage

// File: rtl/rpk_if.sv
`timescale 1ns / 1ps

// Byte input channel
interface rpk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_of_buffer;

  modport source (output valid, output in_byte, output last_of_buffer, input ready);
  modport sink   (input valid, input in_byte, input last_of_buffer, output ready);
endinterface

// Word output channel
interface rpk_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;

  modport source (output valid, output out_word, input ready);
  modport sink   (input valid, input out_word, output ready);
endinterface

// Width register write channel
interface rpk_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] word_width;

  modport source (output valid, output word_width, input ready);
  modport sink   (input valid, input word_width, output ready);
endinterface

// File: rtl/byte_to_nbit_word_repacker_top.sv
`timescale 1ns / 1ps

// Byte to N-bit word repacker.
// s_in carries bytes (in_byte, last_of_buffer); their bits enter MSB first.
// m_out carries completed words of word_width bits, zero-extended to 32 bits,
// the first received bit as the word's MSB. A byte yields zero or one word.
// s_cfg writes word_width (clamped to 8..32); each write clears the
// accumulator and restarts alignment. Write it only while the block is idle.
// A byte with last_of_buffer set emits a word only if it completes one, then drops
// leftover bits. A word is valid on m_out once its closing byte has passed
// the input register and then the output register.
// Throughput: one byte per cycle while m_out does not stall.
// Reset clears the valid flags of both registers, the accumulator and the bit
// count, and sets word_width to 10.
// When m_out stalls, the word holds in the output register and s_in.ready
// drops once the input register is also full; no transaction is lost.
module byte_to_nbit_word_repacker_top
  import rpk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rpk_byte_if.sink    s_in,
  rpk_cfg_if.sink     s_cfg,
  rpk_word_if.source  m_out
);

  rpk_item_t   item;
  rpk_result_t result;
  logic        out_free;

  rpk_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_in       (s_in),
    .out_free_i (out_free),
    .item_o     (item)
  );

  rpk_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_cfg      (s_cfg),
    .item_i     (item),
    .out_free_i (out_free),
    .result_o   (result)
  );

  rpk_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .result_i   (result),
    .out_free_o (out_free),
    .m_out      (m_out)
  );

endmodule

// File: rtl/rpk_in_reg.sv
`timescale 1ns / 1ps

module rpk_in_reg
  import rpk_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  rpk_byte_if.sink       s_in,
  input  logic           out_free_i,
  output rpk_item_t      item_o
);

  logic                  valid_q, valid_d;
  logic [ByteW-1:0]      byte_q;
  logic                  last_q;
  logic                  load;

  // Take a new byte whenever the register is empty or drains this cycle
  assign s_in.ready = !valid_q || out_free_i;
  assign load       = s_in.ready;
  assign valid_d    = s_in.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load && s_in.valid) begin
      byte_q <= s_in.in_byte;
      last_q <= s_in.last_of_buffer;
    end
  end

  assign item_o.valid          = valid_q;
  assign item_o.in_byte        = byte_q;
  assign item_o.last_of_buffer = last_q;

endmodule

// File: rtl/rpk_core.sv
`timescale 1ns / 1ps

module rpk_core
  import rpk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rpk_cfg_if.sink     s_cfg,
  input  rpk_item_t   item_i,
  input  logic        out_free_i,
  output rpk_result_t result_o
);

  logic [WidthW-1:0]      width_q, width_d;
  logic [WordW-1:0]       acc_q, acc_d;
  logic [WidthW-1:0]      held_q, held_d;
  logic                   step;
  logic [WidthW:0]        sum;
  logic                   emit;
  logic [2:0]             shift;
  logic [WordW+ByteW-1:0] joined;
  logic [WordW-1:0]       mask;
  logic [WidthW-1:0]      mask_sh;
  logic [WordW+ByteW-1:0] aligned;

  assign s_cfg.ready = 1'b1;
  assign width_d     = clamp_width(s_cfg.word_width);

  // Advance one byte when the output register can take the result
  assign step = item_i.valid && out_free_i;

  // Bit count after this byte and whether a word completes inside it
  assign sum  = {1'b0, held_q} + (WidthW+1)'(ByteW);
  assign emit = (sum >= {1'b0, width_q});
  // Bits of this byte left over after the word closes
  assign shift = 3'(sum - {1'b0, width_q});

  assign joined  = {acc_q, item_i.in_byte};
  assign mask_sh = WidthMax - width_q;
  assign mask    = {WordW{1'b1}} >> mask_sh;
  assign aligned = joined >> shift;

  // Next accumulator and count; drop partial bits on the last byte
  always_comb begin
    acc_d  = joined[WordW-1:0] & mask;
    held_d = emit ? WidthW'(sum - {1'b0, width_q}) : WidthW'(sum);
    if (item_i.last_of_buffer) begin
      acc_d  = '0;
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
      acc_q   <= '0;
      held_q  <= '0;
    end else if (s_cfg.valid) begin
      // Restart word alignment on a width change
      width_q <= width_d;
      acc_q   <= '0;
      held_q  <= '0;
    end else if (step) begin
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end

  assign result_o.step     = step;
  assign result_o.emit     = emit;
  assign result_o.out_word = aligned[WordW-1:0] & mask;

endmodule

// File: rtl/rpk_out_reg.sv
`timescale 1ns / 1ps

module rpk_out_reg
  import rpk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rpk_result_t result_i,
  output logic        out_free_o,
  rpk_word_if.source  m_out
);

  logic             valid_q, valid_d;
  logic [WordW-1:0] word_q;

  // Register is free when empty or its word leaves this cycle
  assign out_free_o = !valid_q || m_out.ready;
  assign valid_d    = result_i.step && result_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= valid_d;
    end
  end

  // Hold the word while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (out_free_o && valid_d) begin
      word_q <= result_i.out_word;
    end
  end

  assign m_out.valid    = valid_q;
  assign m_out.out_word = word_q;

endmodule
